@@ rtl/ttpm_pkg.sv @@
// ----------------------------------------------------------------------------
// ttpm_pkg
// shared widths, register indexes, reset values and command type of the
// tap tempo period meter
// ----------------------------------------------------------------------------
package ttpm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PERIOD_W   = 24;
  localparam int HYST_W     = 16;
  localparam int MINP_W     = 16;
  localparam int FACT_W     = 8;
  localparam int PROD_W     = PERIOD_W + FACT_W;
  localparam int REM_W      = FACT_W + 1;
  localparam int DIV_STEPS  = PROD_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_PER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLR  = 3'd4;

  // register reset values
  localparam logic [HYST_W-1:0]   HYST_RST     = 16'd96;
  localparam logic [MINP_W-1:0]   MIN_PER_RST  = 16'd5;
  localparam logic [PERIOD_W-1:0] INIT_PER_RST = 24'd24000;
  localparam logic [FACT_W-1:0]   FACT_RST     = 8'd1;

  typedef struct packed {
    logic accept;    // take the request and run the tap logic
    logic mul_go;    // form base period times divider
    logic div_step;  // one restoring division step
    logic out_load;  // load the result register
  } ttpm_cmd_t;

endpackage

@@ rtl/ttpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttpm_ctrl
// sequencer: accept, multiply, bit-serial divide, hand result to the output
// register and track its valid flag
// ----------------------------------------------------------------------------
module ttpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output ttpm_pkg::ttpm_cmd_t cmd
);
  import ttpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.mul_go   = (state_r == S_MUL);
    cmd.div_step = (state_r == S_DIV);
    // result register is free when empty or being drained this cycle
    cmd.out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd.out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_MUL)
    else $error("accepted request did not start the multiply");

  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |=> (state_r == S_DIV && cnt_r == '0))
    else $error("division did not start at step zero");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> state_r == S_DONE)
    else $error("division ran past its last step");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("loaded result not flagged valid");

endmodule

@@ rtl/ttpm_dp.sv @@
// ----------------------------------------------------------------------------
// ttpm_dp
// datapath: config registers, sample clock and tap logic, period multiply,
// bit-serial divide and the result register
// ----------------------------------------------------------------------------
module ttpm_dp #(
  parameter int CLOCK_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ttpm_pkg::ttpm_cmd_t                    cmd,
  input  logic                                   cfg_we,
  input  logic [ttpm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ttpm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic signed [ttpm_pkg::SAMPLE_W-1:0]   in_tap_sample,
  output logic [ttpm_pkg::PERIOD_W-1:0]          out_base_period,
  output logic [ttpm_pkg::PERIOD_W-1:0]          out_derived_period,
  output logic                                   out_tap_seen
);
  import ttpm_pkg::*;

  localparam int EW = (CLOCK_WIDTH > PERIOD_W) ? CLOCK_WIDTH : PERIOD_W;

  logic [HYST_W-1:0]      hyst_r;
  logic [MINP_W-1:0]      min_per_r;
  logic [FACT_W-1:0]      div_r, mul_r;

  logic [CLOCK_WIDTH-1:0] clock_r, clock_nxt;
  logic [CLOCK_WIDTH-1:0] latched_r, latched_nxt;
  logic [PERIOD_W-1:0]    period_r, period_nxt;
  logic                   tap_r;

  logic [PROD_W-1:0]      quo_r;
  logic [REM_W-1:0]       rem_r;

  logic [FACT_W-1:0]      div_eff, mul_eff;
  logic [MINP_W-1:0]      min_eff;
  logic                   tap;
  logic                   replace;
  logic [CLOCK_WIDTH-1:0] clk_diff;
  logic [REM_W-1:0]       rem_sh;
  logic [REM_W:0]         trial;
  logic [PERIOD_W-1:0]    cfg_floor;
  logic [PERIOD_W-1:0]    tap_floor;

  // max(v, lo), then clamp to the period range
  function automatic logic [PERIOD_W-1:0] floor_period(
    input logic [EW-1:0] v,
    input logic [MINP_W-1:0] lo
  );
    logic [EW-1:0] lo_x;
    logic [EW-1:0] p;
    lo_x = EW'(lo);
    p    = (v < lo_x) ? lo_x : v;
    if (p > EW'(PERIOD_MAX)) begin
      p = EW'(PERIOD_MAX);
    end
    return p[PERIOD_W-1:0];
  endfunction

  assign div_eff = (div_r == '0) ? FACT_W'(1) : div_r;
  assign mul_eff = (mul_r == '0) ? FACT_W'(1) : mul_r;
  assign min_eff = (min_per_r == '0) ? MINP_W'(1) : min_per_r;

  assign tap      = (in_tap_sample > $signed(SAMPLE_W'(0)));
  assign clk_diff = clock_r - latched_r;
  assign replace  = (clock_r < latched_r) || (clk_diff > CLOCK_WIDTH'(hyst_r));

  assign cfg_floor = floor_period(EW'(cfg_wdata[PERIOD_W-1:0]), min_eff);
  assign tap_floor = floor_period(EW'(latched_nxt), min_eff);

  always_comb begin
    latched_nxt = latched_r;
    if (replace) begin
      latched_nxt = clock_r;
    end
  end

  always_comb begin
    clock_nxt  = clock_r + 1'b1;
    period_nxt = period_r;
    if (tap) begin
      clock_nxt  = CLOCK_WIDTH'(1);
      period_nxt = tap_floor;
    end
  end

  // config registers and tap state; the initial period also loads the live period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r     <= HYST_RST;
      min_per_r  <= MIN_PER_RST;
      div_r      <= FACT_RST;
      mul_r      <= FACT_RST;
      clock_r    <= '0;
      latched_r  <= '0;
      period_r   <= INIT_PER_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HYST:     hyst_r    <= cfg_wdata[HYST_W-1:0];
          REG_MIN_PER:  min_per_r <= cfg_wdata[MINP_W-1:0];
          REG_INIT_PER: period_r  <= cfg_floor;
          REG_DIVIDER:  div_r     <= cfg_wdata[FACT_W-1:0];
          REG_MULTIPLR: mul_r     <= cfg_wdata[FACT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        clock_r <= clock_nxt;
        if (tap) begin
          latched_r <= latched_nxt;
        end
        period_r <= period_nxt;
      end
    end
  end

  // restoring division, one quotient bit per step, dividend shifted out msb first
  assign rem_sh = {rem_r[REM_W-2:0], quo_r[PROD_W-1]};
  assign trial  = {1'b0, rem_sh} - (REM_W+1)'(mul_eff);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tap_r <= tap;
    end
    if (cmd.mul_go) begin
      quo_r <= PROD_W'(period_r) * PROD_W'(div_eff);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[REM_W]) begin
        rem_r <= trial[REM_W-1:0];
        quo_r <= {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[PROD_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_base_period    <= period_r;
      out_derived_period <= (quo_r[PROD_W-1:PERIOD_W] != '0) ? PERIOD_MAX
                                                              : quo_r[PERIOD_W-1:0];
      out_tap_seen       <= tap_r;
    end
  end

endmodule

@@ rtl/tap_tempo_period_meter_core.sv @@
// an accepted request passes the multiply, the 32-step bit-serial divider and
// the done state, where it waits until the output register can take the result;
// one request is in flight at a time; a finished result waits in the output
// register while the next request is taken
// reset: synchronous, active low; clears control, clock and interval, and
// loads the config registers and base period with their defaults
// ----------------------------------------------------------------------------
// tap_tempo_period_meter_core
// measures the interval between positive samples and reports base and
// scaled period in samples
// ----------------------------------------------------------------------------
module tap_tempo_period_meter_core #(
  parameter int CLOCK_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ttpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttpm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ttpm_pkg::SAMPLE_W-1:0] in_tap_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ttpm_pkg::PERIOD_W-1:0]        out_base_period,
  output logic [ttpm_pkg::PERIOD_W-1:0]        out_derived_period,
  output logic                                 out_tap_seen
);
  import ttpm_pkg::*;

  ttpm_cmd_t cmd;

  ttpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ttpm_dp #(
    .CLOCK_WIDTH (CLOCK_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_tap_sample      (in_tap_sample),
    .out_base_period    (out_base_period),
    .out_derived_period (out_derived_period),
    .out_tap_seen       (out_tap_seen)
  );

endmodule

@@ tb/tap_tempo_period_meter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tap_tempo_period_meter_core_tb
// sends signed samples through the period meter with bursty requests and
// stalls on the result side, predicts base and derived period per request
// and checks every result in order against the prediction
// ----------------------------------------------------------------------------
module tap_tempo_period_meter_core_tb;
  import ttpm_pkg::*;

  localparam int METER_CLOCK_W = 24;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int MAX_REPORTED  = 10;
  localparam int PHASE_ITEMS   = 150;
  localparam int PHASE_COUNT   = 8;
  localparam int TAP_MAX       = 2 ** (SAMPLE_W - 1) - 1;
  localparam logic [CFG_IDX_W-1:0] LAST_INDEX = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [PERIOD_W-1:0] base;
    logic [PERIOD_W-1:0] derived;
    logic                tap;
  } period_report_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                        clk;
  logic                        rst_n         = 1'b0;
  logic                        cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index     = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata     = '0;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_tap_sample = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic [PERIOD_W-1:0]         out_base_period;
  logic [PERIOD_W-1:0]         out_derived_period;
  logic                        out_tap_seen;

  // predicted registers and state of the meter
  logic [HYST_W-1:0]        hyst_reg        = HYST_RST;
  logic [MINP_W-1:0]        min_period_reg  = MIN_PER_RST;
  logic [PERIOD_W-1:0]      init_period_reg = INIT_PER_RST;
  logic [FACT_W-1:0]        divider_reg     = FACT_RST;
  logic [FACT_W-1:0]        multiplier_reg  = FACT_RST;
  logic [METER_CLOCK_W-1:0] sample_count    = '0;
  logic [METER_CLOCK_W-1:0] held_interval   = '0;
  logic [PERIOD_W-1:0]      base_period     = INIT_PER_RST;

  period_report_t expected_reports[$];

  int mismatches;
  int reports_checked;
  int taps_seen;
  int intervals_replaced;
  int saturated_reports;
  int zero_reports;
  int burst_left;
  int stall_span;
  stall_mode_t stall_mode;

  tap_tempo_period_meter_core #(
    .CLOCK_WIDTH(METER_CLOCK_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_tap_sample      (in_tap_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_base_period    (out_base_period),
    .out_derived_period (out_derived_period),
    .out_tap_seen       (out_tap_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [PERIOD_W-1:0] floor_to_min(input logic [31:0] span);
    logic [32:0] lo;
    logic [32:0] p;
    lo = (min_period_reg == '0) ? 33'd1 : 33'(min_period_reg);
    p  = (33'(span) < lo) ? lo : 33'(span);
    return (p > 33'(PERIOD_MAX)) ? PERIOD_MAX : p[PERIOD_W-1:0];
  endfunction

  function automatic period_report_t advance_meter(input logic signed [SAMPLE_W-1:0] sample);
    period_report_t    rep;
    logic [FACT_W-1:0] div_eff;
    logic [FACT_W-1:0] mul_eff;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] quotient;
    rep.tap = (sample > 0);
    if (rep.tap) begin
      // a shorter interval always wins, a longer one only past the hysteresis
      if (sample_count < held_interval || (sample_count - held_interval) > hyst_reg) begin
        held_interval = sample_count;
        intervals_replaced++;
      end
      base_period  = floor_to_min(32'(held_interval));
      sample_count = '0;
      taps_seen++;
    end
    sample_count = sample_count + 1'b1;
    div_eff  = (divider_reg == '0) ? FACT_W'(1) : divider_reg;
    mul_eff  = (multiplier_reg == '0) ? FACT_W'(1) : multiplier_reg;
    product  = base_period * div_eff;
    quotient = product / mul_eff;
    rep.base = base_period;
    if (quotient > PROD_W'(PERIOD_MAX)) begin
      rep.derived = PERIOD_MAX;
      saturated_reports++;
    end else begin
      rep.derived = quotient[PERIOD_W-1:0];
    end
    if (rep.derived == '0) zero_reports++;
    return rep;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      REG_HYST:     hyst_reg       = value[HYST_W-1:0];
      REG_MIN_PER:  min_period_reg = value[MINP_W-1:0];
      REG_INIT_PER: begin
        init_period_reg = value[PERIOD_W-1:0];
        base_period     = floor_to_min(32'(init_period_reg));
      end
      REG_DIVIDER:  divider_reg    = value[FACT_W-1:0];
      REG_MULTIPLR: multiplier_reg = value[FACT_W-1:0];
      default: ;
    endcase
  endtask

  // hold off requests until every predicted result has come back or the drain limit is reached
  task automatic drain_reports();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (expected_reports.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic configure_meter(input logic [HYST_W-1:0]   hyst,
                                 input logic [MINP_W-1:0]   min_period,
                                 input logic [PERIOD_W-1:0] init_period,
                                 input logic [FACT_W-1:0]   div_factor,
                                 input logic [FACT_W-1:0]   mul_factor);
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // minimum goes in before the initial period, whose write applies the floor
    write_reg(REG_HYST, CFG_DATA_W'(hyst));
    write_reg(REG_MIN_PER, CFG_DATA_W'(min_period));
    write_reg(REG_INIT_PER, CFG_DATA_W'(init_period));
    write_reg(REG_DIVIDER, CFG_DATA_W'(div_factor));
    write_reg(REG_MULTIPLR, CFG_DATA_W'(mul_factor));
  endtask

  // one request, sent in bursts with random gaps between them
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_tap_sample <= sample;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_reports.push_back(advance_meter(sample));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] quiet_sample();
    return ($urandom_range(3, 0) == 0) ? '0 : {1'b1, (SAMPLE_W-1)'($urandom)};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] tap_sample();
    return SAMPLE_W'($urandom_range(TAP_MAX, 1));
  endfunction

  // quiet samples followed by a tap, so the tap measures span samples
  task automatic send_interval(input int span);
    repeat (span - 1) send_sample(quiet_sample());
    send_sample(tap_sample());
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(3, 0));
      stall_span = $urandom_range(400, 50);
    end
    stall_span--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(9, 0) < 3);
      STALL_HEAVY: out_stall <= ($urandom_range(9, 0) < 8);
      default:     out_stall <= ((stall_span % 16) < 5);
    endcase
  end

  always @(posedge clk) begin : check_results
    period_report_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_reports.size() == 0) begin
        if (mismatches < MAX_REPORTED)
          $display("%0t: result with none expected: base %0d derived %0d tap %0b",
                   $time, out_base_period, out_derived_period, out_tap_seen);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (out_base_period !== want.base || out_derived_period !== want.derived ||
            out_tap_seen !== want.tap) begin
          if (mismatches < MAX_REPORTED)
            $display("%0t: result %0d expected base %0d derived %0d tap %0b, got %0d %0d %0b",
                     $time, reports_checked, want.base, want.derived, want.tap,
                     out_base_period, out_derived_period, out_tap_seen);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // field extremes and the sign boundary of a tap
  task automatic test_sample_threshold();
    send_sample(16'sd0);
    send_sample(-16'sd32768);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sd32767);
  endtask

  // growth by exactly the hysteresis holds, one more replaces, shorter replaces
  task automatic test_hysteresis();
    configure_meter(16'd1, 16'd1, INIT_PER_RST, FACT_RST, FACT_RST);
    send_interval(4);
    send_interval(5);
    send_interval(6);
    send_interval(2);
  endtask

  // zero floor, saturation of the derived period and truncation to zero
  task automatic test_config_extremes();
    configure_meter('0, '0, '0, FACT_RST, FACT_RST);
    send_sample(quiet_sample());
    configure_meter('1, '1, PERIOD_MAX, '1, '0);
    send_sample(quiet_sample());
    configure_meter('0, 16'd1, 24'd5, '0, '1);
    send_sample(quiet_sample());
  endtask

  // writes to indexes past the last register change nothing
  task automatic test_unused_indexes();
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int idx = int'(REG_MULTIPLR) + 1; idx <= int'(LAST_INDEX); idx++)
      write_reg(CFG_IDX_W'(idx), '1);
    send_sample(-16'sd1);
  endtask

  // mostly regular tap trains with jitter around the hysteresis, plus noise
  task automatic test_tap_sequences();
    int sent;
    int target;
    int target_max;
    int spread;
    int gap;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: configure_meter(HYST_RST, MIN_PER_RST, INIT_PER_RST, FACT_RST, FACT_RST);
        1: configure_meter('0, 16'd1, 24'd1, '1, 8'd1);
        2: configure_meter('1, '1, PERIOD_MAX, '1, '1);
        3: configure_meter(HYST_W'($urandom_range(30, 0)), MINP_W'($urandom_range(8, 0)),
                           PERIOD_W'($urandom), '0, '0);
        default: configure_meter(HYST_W'($urandom_range(40, 0)),
                                 MINP_W'($urandom_range(12, 0)), PERIOD_W'($urandom),
                                 FACT_W'($urandom), FACT_W'($urandom));
      endcase
      spread     = (hyst_reg > 40) ? 40 : int'(hyst_reg);
      target_max = (hyst_reg > 60) ? 150 : 60;
      target     = $urandom_range(target_max, 1);
      sent       = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(19, 0) == 0) drain_reports();
        if ($urandom_range(9, 0) == 0) begin
          send_sample(SAMPLE_W'($urandom));
          sent++;
        end else begin
          if ($urandom_range(4, 0) == 0) target = $urandom_range(target_max, 1);
          gap = target + $urandom_range(2 * spread + 4, 0) - spread - 2;
          if (gap < 1) gap = 1;
          send_interval(gap);
          sent += gap;
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sample_threshold();
    test_hysteresis();
    test_config_extremes();
    test_unused_indexes();
    test_tap_sequences();
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0d expected results never arrived", expected_reports.size());
      mismatches += expected_reports.size();
    end
    $display("checked %0d results: %0d taps, %0d interval updates",
             reports_checked, taps_seen, intervals_replaced);
    $display("derived period saturated %0d times and truncated to zero %0d times",
             saturated_reports, zero_reports);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
